// ===== sv/binary_trie_longest_prefix_match_core_defines.svh =====
// assertion helpers for the trie route table core
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_CORE_DEFINES_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BTLPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTLPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BTLPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BTLPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/btlpm_pkg.sv =====
package btlpm_pkg;

    localparam int NODE_COUNT   = 4096;
    localparam int ADDRESS_BITS = 32;

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int POS_W  = 5;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } t_in_word;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] matched_prefix;
        logic [LEN_W-1:0]  matched_length;
        logic              table_full;
    } t_out_word;

    typedef struct packed {
        logic [IDX_W-1:0]  child0;
        logic [IDX_W-1:0]  child1;
        logic              marked;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  plen;
    } t_node;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_node            wr_data;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_HOLD
    } t_walk_state;

endpackage

// ===== sv/binary_trie_longest_prefix_match_core.sv =====
// IPv4 route table held as a one-bit trie in a single node memory (4096
// nodes of child0, child1, mark, prefix and length). Each input word is an
// insert (command 0) or a lookup (command 1) and gives exactly one result
// word. A word of length L (saturated to 32) runs in steps: accept and start
// the root read, visit the trie nodes (L+1 at most, one node per cycle through
// the single read port of the node memory), and hand the result to the output
// register once it can take it. Lookups that fall off the
// trie early finish sooner. Only one word is in flight at a time; the input
// stalls while the walk runs, and the output register lets a new word start
// while the previous result still waits. No clearing pass runs after reset:
// the root reads as empty until first written, and other nodes are written
// when allocated. An insert that runs out of nodes reports table_full and
// leaves the nodes it already allocated in place, unmarked.

`include "binary_trie_longest_prefix_match_core_defines.svh"

module binary_trie_longest_prefix_match_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  btlpm_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output btlpm_pkg::t_out_word  o_out_word
);

    logic                  in_accept;
    logic                  walk_busy;
    logic                  res_valid;
    logic                  res_take;
    btlpm_pkg::t_out_word  res_word;
    btlpm_pkg::t_mem_req   mem_req;
    btlpm_pkg::t_node      mem_rd_data;

    // output register
    logic                  r_out_valid, n_out_valid;
    btlpm_pkg::t_out_word  r_out_word, n_out_word;

    // accept only while the walker is idle
    assign o_in_stall = walk_busy;
    assign in_accept  = i_in_valid && !walk_busy;

    // result moves when the output register is empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    btlpm_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_word      (i_in_word),
        .o_busy      (walk_busy),
        .o_res_valid (res_valid),
        .o_res       (res_word),
        .i_res_take  (res_take),
        .o_req       (mem_req),
        .i_rd_data   (mem_rd_data)
    );

    btlpm_node_ram u_node_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (res_take) begin
            n_out_valid = 1'b1;
            n_out_word  = res_word;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a started walk holds off the next word
    `BTLPM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_in_stall, "walk not busy after accept")

    // a full table only comes from an insert, which never reports a match
    `BTLPM_ASSERT_IMP(a_full_no_match, i_clk, i_rst_n, o_out_valid && o_out_word.table_full, !o_out_word.found && (o_out_word.matched_length == '0), "table_full word carries a match")

    // no match means zero prefix and length
    `BTLPM_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.found, (o_out_word.matched_prefix == '0) && (o_out_word.matched_length == '0), "miss word with nonzero match fields")

endmodule

// ===== sv/btlpm_node_ram.sv =====
module btlpm_node_ram (
    input  logic                i_clk,
    input  btlpm_pkg::t_mem_req i_req,
    output btlpm_pkg::t_node    o_rd_data
);

    btlpm_pkg::t_node mem [btlpm_pkg::NODE_COUNT];
    btlpm_pkg::t_node r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/btlpm_walker.sv =====
module btlpm_walker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  btlpm_pkg::t_in_word   i_word,
    output logic                  o_busy,
    output logic                  o_res_valid,
    output btlpm_pkg::t_out_word  o_res,
    input  logic                  i_res_take,
    output btlpm_pkg::t_mem_req   o_req,
    input  btlpm_pkg::t_node      i_rd_data
);

    localparam logic [btlpm_pkg::FREE_W-1:0] FREE_LIMIT =
        btlpm_pkg::FREE_W'(btlpm_pkg::NODE_COUNT);

    btlpm_pkg::t_walk_state r_state, n_state;

    logic                             r_cmd, n_cmd;
    logic [btlpm_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [btlpm_pkg::LEN_W-1:0]      r_len, n_len;
    logic [btlpm_pkg::LEN_W-1:0]      r_depth, n_depth;
    logic [btlpm_pkg::IDX_W-1:0]      r_cur, n_cur;
    logic [btlpm_pkg::FREE_W-1:0]     r_free, n_free;
    logic                             r_root_written, n_root_written;
    logic                             r_fresh, n_fresh;
    logic                             r_found, n_found;
    logic [btlpm_pkg::ADDR_W-1:0]     r_mp, n_mp;
    logic [btlpm_pkg::LEN_W-1:0]      r_ml, n_ml;
    logic                             r_full, n_full;

    btlpm_pkg::t_node             node;
    btlpm_pkg::t_node             node_mod;
    logic [btlpm_pkg::POS_W-1:0]  bit_pos;
    logic                         dir;
    logic [btlpm_pkg::IDX_W-1:0]  nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= btlpm_pkg::S_IDLE;
            r_free         <= btlpm_pkg::FREE_W'(1);
            r_root_written <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_free         <= n_free;
            r_root_written <= n_root_written;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_len   <= n_len;
        r_depth <= n_depth;
        r_cur   <= n_cur;
        r_fresh <= n_fresh;
        r_found <= n_found;
        r_mp    <= n_mp;
        r_ml    <= n_ml;
        r_full  <= n_full;
    end

    // current node: a fresh allocation or an unwritten root reads as zero
    always_comb begin
        if (r_fresh || ((r_cur == '0) && !r_root_written)) begin
            node = '0;
        end else begin
            node = i_rd_data;
        end
        bit_pos = btlpm_pkg::POS_W'(btlpm_pkg::ADDRESS_BITS - 1) -
                  r_depth[btlpm_pkg::POS_W-1:0];
        dir     = r_addr[bit_pos];
        nxt     = dir ? node.child1 : node.child0;
    end

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_addr         = r_addr;
        n_len          = r_len;
        n_depth        = r_depth;
        n_cur          = r_cur;
        n_free         = r_free;
        n_root_written = r_root_written;
        n_fresh        = r_fresh;
        n_found        = r_found;
        n_mp           = r_mp;
        n_ml           = r_ml;
        n_full         = r_full;
        node_mod       = node;
        o_req          = '0;

        unique case (r_state)
            btlpm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_word.command;
                    n_addr  = i_word.address & btlpm_pkg::ADDR_MASK;
                    n_len   = (i_word.length > btlpm_pkg::LEN_W'(btlpm_pkg::ADDRESS_BITS)) ?
                              btlpm_pkg::LEN_W'(btlpm_pkg::ADDRESS_BITS) : i_word.length;
                    n_depth = '0;
                    n_cur   = '0;
                    n_fresh = 1'b0;
                    n_found = 1'b0;
                    n_mp    = '0;
                    n_ml    = '0;
                    n_full  = 1'b0;
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = '0;
                    n_state = btlpm_pkg::S_EVAL;
                end
            end

            btlpm_pkg::S_EVAL: begin
                if (r_cmd == btlpm_pkg::CMD_LOOKUP) begin
                    if (node.marked) begin
                        n_found = 1'b1;
                        n_mp    = node.prefix;
                        n_ml    = node.plen;
                    end
                    if ((r_depth >= r_len) || (nxt == '0)) begin
                        n_state = btlpm_pkg::S_HOLD;
                    end else begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = nxt;
                        n_cur   = nxt;
                        n_depth = r_depth + btlpm_pkg::LEN_W'(1);
                        n_fresh = 1'b0;
                    end
                end else begin
                    if (r_depth >= r_len) begin
                        // mark the end node
                        node_mod.marked = 1'b1;
                        node_mod.prefix = r_addr;
                        node_mod.plen   = r_len;
                        o_req.wr_en   = 1'b1;
                        o_req.wr_addr = r_cur;
                        o_req.wr_data = node_mod;
                        if (r_cur == '0) begin
                            n_root_written = 1'b1;
                        end
                        n_state = btlpm_pkg::S_HOLD;
                    end else if (nxt != '0) begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = nxt;
                        n_cur   = nxt;
                        n_depth = r_depth + btlpm_pkg::LEN_W'(1);
                        n_fresh = 1'b0;
                    end else if (r_free >= FREE_LIMIT) begin
                        // a node taken just before the pool ran dry is stored empty
                        if (r_fresh) begin
                            o_req.wr_en   = 1'b1;
                            o_req.wr_addr = r_cur;
                            o_req.wr_data = node_mod;
                        end
                        n_full  = 1'b1;
                        n_state = btlpm_pkg::S_HOLD;
                    end else begin
                        // link a new child; the new node itself starts as zero
                        if (dir) begin
                            node_mod.child1 = r_free[btlpm_pkg::IDX_W-1:0];
                        end else begin
                            node_mod.child0 = r_free[btlpm_pkg::IDX_W-1:0];
                        end
                        o_req.wr_en   = 1'b1;
                        o_req.wr_addr = r_cur;
                        o_req.wr_data = node_mod;
                        if (r_cur == '0) begin
                            n_root_written = 1'b1;
                        end
                        n_cur   = r_free[btlpm_pkg::IDX_W-1:0];
                        n_free  = r_free + btlpm_pkg::FREE_W'(1);
                        n_depth = r_depth + btlpm_pkg::LEN_W'(1);
                        n_fresh = 1'b1;
                    end
                end
            end

            btlpm_pkg::S_HOLD: begin
                if (i_res_take) begin
                    n_state = btlpm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = btlpm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != btlpm_pkg::S_IDLE);
    assign o_res_valid = (r_state == btlpm_pkg::S_HOLD);

    always_comb begin
        o_res.found          = r_found;
        o_res.matched_prefix = r_mp;
        o_res.matched_length = r_ml;
        o_res.table_full     = r_full;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int BOOK_DEPTH   = 256;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    btlpm_pkg::t_in_word  in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    btlpm_pkg::t_out_word out_word;

    binary_trie_longest_prefix_match_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // mirror of the route trie
    logic [btlpm_pkg::IDX_W-1:0]  kid0        [btlpm_pkg::NODE_COUNT];
    logic [btlpm_pkg::IDX_W-1:0]  kid1        [btlpm_pkg::NODE_COUNT];
    logic                         node_mark   [btlpm_pkg::NODE_COUNT];
    logic [btlpm_pkg::ADDR_W-1:0] node_prefix [btlpm_pkg::NODE_COUNT];
    logic [btlpm_pkg::LEN_W-1:0]  node_len    [btlpm_pkg::NODE_COUNT];
    int                           free_node;

    btlpm_pkg::t_out_word         route_results [$];
    logic [btlpm_pkg::ADDR_W-1:0] routes_book   [$];
    logic [7:0]                   base_book     [12];

    int cycle_count = 0;
    int burst_left  = 0;
    int n_insert    = 0;
    int n_lookup    = 0;
    int n_hit       = 0;
    int n_full      = 0;
    int n_fail      = 0;
    int stall_pct   = 0;
    int stall_hold  = 0;
    btlpm_pkg::t_out_word want;

    // walk the mirror trie for one word and return the result word it should give
    function automatic btlpm_pkg::t_out_word route_predict(input btlpm_pkg::t_in_word w);
        btlpm_pkg::t_out_word         r;
        logic [btlpm_pkg::ADDR_W-1:0] a;
        int                           len;
        int                           cur;
        int                           nxt;
        int                           d;
        logic                         b;
        logic                         done;
        r   = '0;
        a   = w.address & btlpm_pkg::ADDR_MASK;
        // lengths past the address width saturate
        len = (int'(w.length) > btlpm_pkg::ADDRESS_BITS) ?
              btlpm_pkg::ADDRESS_BITS : int'(w.length);
        cur = 0;
        if (w.command == btlpm_pkg::CMD_INSERT) begin
            for (d = 0; d < len; d++) begin
                b   = a[btlpm_pkg::ADDRESS_BITS-1-d];
                nxt = b ? int'(kid1[cur]) : int'(kid0[cur]);
                if (nxt == 0) begin
                    // pool dry: nodes taken so far stay, route is not marked
                    if (free_node >= btlpm_pkg::NODE_COUNT) begin
                        r.table_full = 1'b1;
                        return r;
                    end
                    nxt = free_node;
                    free_node++;
                    kid0[nxt]        = '0;
                    kid1[nxt]        = '0;
                    node_mark[nxt]   = 1'b0;
                    node_prefix[nxt] = '0;
                    node_len[nxt]    = '0;
                    if (b) begin
                        kid1[cur] = btlpm_pkg::IDX_W'(nxt);
                    end else begin
                        kid0[cur] = btlpm_pkg::IDX_W'(nxt);
                    end
                end
                cur = nxt;
            end
            // re-insert just rewrites the mark
            node_mark[cur]   = 1'b1;
            node_prefix[cur] = a;
            node_len[cur]    = btlpm_pkg::LEN_W'(len);
        end else begin
            d    = 0;
            done = 1'b0;
            while (!done) begin
                // deepest mark on the path wins, root and stop node included
                if (node_mark[cur]) begin
                    r.found          = 1'b1;
                    r.matched_prefix = node_prefix[cur];
                    r.matched_length = node_len[cur];
                end
                if (d >= len) begin
                    done = 1'b1;
                end else begin
                    b   = a[btlpm_pkg::ADDRESS_BITS-1-d];
                    nxt = b ? int'(kid1[cur]) : int'(kid0[cur]);
                    if (nxt == 0) begin
                        done = 1'b1;
                    end else begin
                        cur = nxt;
                        d++;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void book_route(input logic [btlpm_pkg::ADDR_W-1:0] a);
        if (routes_book.size() < BOOK_DEPTH) begin
            routes_book.push_back(a);
        end else begin
            routes_book[$urandom_range(0, BOOK_DEPTH - 1)] = a;
        end
    endfunction

    // present one word, hold it until taken, then maybe open a gap
    task automatic send_word(input logic cmd, input logic [btlpm_pkg::ADDR_W-1:0] addr,
                             input logic [btlpm_pkg::LEN_W-1:0] len);
        btlpm_pkg::t_in_word w;
        int                  gap;
        w.command = cmd;
        w.address = addr;
        w.length  = len;
        route_results.push_back(route_predict(w));
        if (cmd == btlpm_pkg::CMD_INSERT) begin
            n_insert++;
        end else begin
            n_lookup++;
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // sender stays quiet until every result word is back
    task automatic drain_results;
        in_valid <= 1'b0;
        while (route_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed;
        // empty table, incl. saturated depth
        send_word(btlpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd32);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63);
        // default route, then root-only lookup
        send_word(btlpm_pkg::CMD_INSERT, 32'h0000_0000, 6'd0);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'h1234_5678, 6'd32);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);
        // nested routes: longest wins, depth limit cuts it short
        send_word(btlpm_pkg::CMD_INSERT, 32'hC0A8_0000, 6'd16);
        send_word(btlpm_pkg::CMD_INSERT, 32'hC0A8_0100, 6'd24);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_0105, 6'd32);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_0105, 6'd20);
        // walk falls off the trie early
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hC0A9_0000, 6'd32);
        // full-length extremes
        send_word(btlpm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd32);
        send_word(btlpm_pkg::CMD_INSERT, 32'h0000_0000, 6'd32);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd32);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd32);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'h0000_0001, 6'd32);
        // insert length saturates and is stored saturated
        send_word(btlpm_pkg::CMD_INSERT, 32'hAAAA_AAAA, 6'd45);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hAAAA_AAAA, 6'd40);
        // re-insert rewrites prefix of an existing mark
        send_word(btlpm_pkg::CMD_INSERT, 32'hC0A8_FFFF, 6'd16);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'hC0A8_1234, 6'd32);
        // one-bit route and a rewritten default route
        send_word(btlpm_pkg::CMD_INSERT, 32'h8000_0000, 6'd1);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'h8765_4321, 6'd1);
        send_word(btlpm_pkg::CMD_INSERT, 32'hDEAD_BEEF, 6'd0);
        send_word(btlpm_pkg::CMD_LOOKUP, 32'h7000_0000, 6'd63);
    endtask

    // mostly routes under a few shared /8 blocks and lookups near them, plus noise
    task automatic test_route_mix(input int count);
        logic [btlpm_pkg::ADDR_W-1:0] a;
        logic [btlpm_pkg::LEN_W-1:0]  l;
        repeat (count) begin
            if ($urandom_range(0, 99) < 45) begin
                if ($urandom_range(0, 9) < 7) begin
                    a = {base_book[$urandom_range(0, 11)], 24'($urandom)};
                    l = btlpm_pkg::LEN_W'($urandom_range(8, 28));
                end else begin
                    a = $urandom;
                    l = btlpm_pkg::LEN_W'($urandom_range(0, 63));
                end
                send_word(btlpm_pkg::CMD_INSERT, a, l);
                book_route(a);
            end else begin
                if (routes_book.size() != 0 && $urandom_range(0, 9) < 6) begin
                    a = routes_book[$urandom_range(0, routes_book.size() - 1)];
                    a = a ^ ($urandom >> $urandom_range(8, 32));
                end else begin
                    a = $urandom;
                end
                l = ($urandom_range(0, 2) == 0) ?
                    btlpm_pkg::LEN_W'($urandom_range(0, 63)) : 6'd32;
                send_word(btlpm_pkg::CMD_LOOKUP, a, l);
            end
        end
    endtask

    // fill the node pool with host routes, then poke the dry pool
    task automatic test_pool_exhaust;
        logic [btlpm_pkg::ADDR_W-1:0] a;
        int                           k;
        while (free_node < btlpm_pkg::NODE_COUNT) begin
            a = $urandom;
            send_word(btlpm_pkg::CMD_INSERT, a, 6'd32);
            book_route(a);
        end
        for (k = 0; k < 12; k++) begin
            a = routes_book[$urandom_range(0, routes_book.size() - 1)];
            case (k % 4)
                0: send_word(btlpm_pkg::CMD_INSERT, $urandom, 6'd32);
                1: send_word(btlpm_pkg::CMD_INSERT, a, 6'd32);
                2: send_word(btlpm_pkg::CMD_INSERT, $urandom, 6'd0);
                default: send_word(btlpm_pkg::CMD_LOOKUP, a, 6'd32);
            endcase
        end
    endtask

    // receiver stall: random stall rate, redrawn when its hold count runs out
    always @(posedge clk) begin
        if (stall_hold == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
            stall_hold <= $urandom_range(50, 400);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result check against the oldest pending word
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (route_results.size() == 0) begin
                $error("result word with nothing pending");
                n_fail++;
            end else begin
                want = route_results.pop_front();
                if (want.found) n_hit++;
                if (want.table_full) n_full++;
                if (out_word.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, out_word.found);
                    n_fail++;
                end
                if (out_word.matched_prefix !== want.matched_prefix) begin
                    $error("matched_prefix: expected %h, got %h",
                           want.matched_prefix, out_word.matched_prefix);
                    n_fail++;
                end
                if (out_word.matched_length !== want.matched_length) begin
                    $error("matched_length: expected %0d, got %0d",
                           want.matched_length, out_word.matched_length);
                    n_fail++;
                end
                if (out_word.table_full !== want.table_full) begin
                    $error("table_full: expected %0b, got %0b",
                           want.table_full, out_word.table_full);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int i;
        // root starts empty, pool pointer at one
        kid0[0]        = '0;
        kid1[0]        = '0;
        node_mark[0]   = 1'b0;
        node_prefix[0] = '0;
        node_len[0]    = '0;
        free_node      = 1;
        base_book[0]   = 8'h00;
        base_book[1]   = 8'hFF;
        for (i = 2; i < 12; i++) base_book[i] = 8'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed;
        drain_results;
        test_route_mix(330);
        drain_results;
        test_pool_exhaust;
        test_route_mix(150);

        drain_results;
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d inserts (%0d refused on a dry pool, %0d nodes used)",
                 n_insert, n_full, free_node);
        $display("and %0d lookups (%0d matched a route), under random gaps and stalls",
                 n_lookup, n_hit);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== binary_trie_longest_prefix_match_core.f =====
+incdir+sv
sv/btlpm_pkg.sv
sv/btlpm_node_ram.sv
sv/btlpm_walker.sv
sv/binary_trie_longest_prefix_match_core.sv
dv/testbench.sv
